/* src/indexed_sequence_store_defines.svh */
// ----------------------------------------------------------------------------
// Indexed sequence store assertion macros
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

// same-cycle implication
`define ISS_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ISS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/iss_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed sequence store package
// Field widths, request and status codes, controller states and cell command.
// ----------------------------------------------------------------------------
package iss_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int WORD_W          = 32;
	localparam int POS_W           = 6;
	localparam int REQ_W           = 3;
	localparam int STATUS_W        = 2;
	localparam int CNT_OUT_W       = 7;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_INSERT     = 3'd4,
		REQ_ERASE      = 3'd5,
		REQ_READ       = 3'd6,
		REQ_CLEAR      = 3'd7
	} req_e_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_EMPTY = 2'd3
	} status_e_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_REPLY
	} state_e_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_OPEN,
		CELL_CLOSE
	} cell_op_e_t;

	typedef struct packed {
		cell_op_e_t        op;
		logic              tap_load;
		logic              tap_shift;
		logic [WORD_W-1:0] fill;
	} cell_cmd_t;

endpackage

/* src/iss_cell.sv */
// ----------------------------------------------------------------------------
// Indexed sequence store cell
// One stored word plus one tap word; opens or closes a gap around the
// broadcast index and passes its tap toward the head.
// ----------------------------------------------------------------------------
module iss_cell #(
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  iss_pkg::cell_cmd_t        cmd,
	input  logic [IW-1:0]             idx,
	input  logic [iss_pkg::WORD_W-1:0] left_word,
	input  logic [iss_pkg::WORD_W-1:0] right_word,
	input  logic [iss_pkg::WORD_W-1:0] right_tap,
	output logic [iss_pkg::WORD_W-1:0] word,
	output logic [iss_pkg::WORD_W-1:0] tap
);
	import iss_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] tap_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_OPEN: begin
				if (MY_IDX > idx) begin
					word_q <= left_word;
				end else if (MY_IDX == idx) begin
					word_q <= cmd.fill;
				end
			end
			CELL_CLOSE: begin
				if (MY_IDX >= idx) begin
					word_q <= right_word;
				end
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.tap_load) begin
			tap_q <= word_q;
		end else if (cmd.tap_shift) begin
			tap_q <= right_tap;
		end
	end

	assign word = word_q;
	assign tap  = tap_q;

endmodule

/* src/iss_ctrl.sv */
// ----------------------------------------------------------------------------
// Indexed sequence store controller
// Decodes requests, keeps the entry count, drives the cell row and walks the
// tap chain until the addressed word reaches the head.
// ----------------------------------------------------------------------------
`include "indexed_sequence_store_defines.svh"

module iss_ctrl #(
	parameter int MAX_ENTRIES = 64,
	parameter int IW          = 6,
	parameter int CW          = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [iss_pkg::REQ_W-1:0]     req_type,
	input  logic [iss_pkg::POS_W-1:0]     position,
	input  logic [iss_pkg::WORD_W-1:0]    value_in,
	input  logic [iss_pkg::WORD_W-1:0]    tap_head,
	output logic                          busy,
	output logic                          done,
	output logic [iss_pkg::WORD_W-1:0]    value_out,
	output logic [iss_pkg::STATUS_W-1:0]  status,
	output logic [iss_pkg::CNT_OUT_W-1:0] entry_count,
	output iss_pkg::cell_cmd_t            cmd,
	output logic [IW-1:0]                 cmd_idx
);
	import iss_pkg::*;

	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	state_e_t  state_q, state_d;
	status_e_t status_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] rem_q;
	logic          need_q;

	logic          accept;
	logic          full;
	logic          empty;
	logic          in_range;
	status_e_t     dec_status;
	logic [CW-1:0] dec_count;
	cell_op_e_t    dec_op;
	logic [IW-1:0] dec_idx;
	logic          dec_need;
	logic          tap_shift;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;

	assign accept   = start && (state_q == S_IDLE);
	assign full     = (count_q == CW'(MAX_ENTRIES));
	assign empty    = (count_q == '0);
	assign in_range = (CMPW'(position) < CMPW'(count_q));

	// request decode
	always_comb begin
		dec_status = STAT_OK;
		dec_count  = count_q;
		dec_op     = CELL_HOLD;
		dec_idx    = '0;
		dec_need   = 1'b0;
		case (req_e_t'(req_type))
			REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
				if (full) begin
					dec_status = STAT_FULL;
				end else begin
					dec_op    = CELL_OPEN;
					dec_count = count_q + CW'(1);
					if (req_e_t'(req_type) == REQ_PUSH_FRONT) begin
						dec_idx = '0;
					end else if (req_e_t'(req_type) == REQ_INSERT && in_range) begin
						dec_idx = IW'(position);
					end else begin
						dec_idx = IW'(count_q);
					end
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (empty) begin
					dec_status = STAT_EMPTY;
				end else begin
					dec_op    = CELL_CLOSE;
					dec_need  = 1'b1;
					dec_count = count_q - CW'(1);
					if (req_e_t'(req_type) == REQ_POP_BACK) begin
						dec_idx = IW'(count_q - CW'(1));
					end
				end
			end
			REQ_ERASE, REQ_READ: begin
				if (!in_range) begin
					dec_status = STAT_RANGE;
				end else begin
					dec_need = 1'b1;
					dec_idx  = IW'(position);
					if (req_e_t'(req_type) == REQ_ERASE) begin
						dec_op    = CELL_CLOSE;
						dec_count = count_q - CW'(1);
					end
				end
			end
			default: begin
				dec_count = '0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (dec_need && dec_idx != '0) ? S_SHIFT : S_REPLY;
				end
			end
			S_SHIFT: begin
				if (rem_q == IW'(1)) begin
					state_d = S_REPLY;
				end
			end
			S_REPLY: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy      = 1'b1;
		done      = 1'b0;
		tap_shift = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
			end
			S_SHIFT: begin
				tap_shift = 1'b1;
			end
			S_REPLY: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			status_q <= STAT_OK;
			need_q   <= 1'b0;
			rem_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q  <= dec_count;
				status_q <= dec_status;
				need_q   <= dec_need;
				rem_q    <= dec_idx;
			end else if (state_q == S_SHIFT) begin
				rem_q <= rem_q - IW'(1);
			end
		end
	end

	assign cmd.op        = accept ? dec_op : CELL_HOLD;
	assign cmd.tap_load  = accept;
	assign cmd.tap_shift = tap_shift;
	assign cmd.fill      = value_in;
	assign cmd_idx       = dec_idx;

	assign cnt_ext     = {{CNT_OUT_W{1'b0}}, count_q};
	assign entry_count = cnt_ext[CNT_OUT_W-1:0];
	assign status      = status_q;
	assign value_out   = need_q ? tap_head : '0;

	`ISS_CHECK_NEXT(a_single_strobe, done, !done, "result strobe held past one cycle")
	`ISS_CHECK_NEXT(a_busy_after_accept, accept, busy, "not busy after accepting a word")
	`ISS_CHECK_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_ENTRIES), "entry count past capacity")
	`ISS_CHECK_NOW(a_fail_zero, done && status_q != STAT_OK, value_out == '0,
		"nonzero word on a failed request")

endmodule

/* src/indexed_sequence_store.sv */
// The strobe comes from the reply state, straight after acceptance for requests that
// return no word or the word at index 0, else after the shift state counts down
// the index (pop back: entry count minus one). The addressed word walks the tap chain
// one cell per cycle to the head. busy stays high through the strobe, and a request
// is taken only in idle. Reset clears count and control; stored words stay undefined.
// ----------------------------------------------------------------------------
// Indexed sequence store
// Bounded ordered store of unsigned 32-bit words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
module indexed_sequence_store #(
	parameter int MAX_ENTRIES = iss_pkg::MAX_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [iss_pkg::REQ_W-1:0]     req_type,
	input  logic [iss_pkg::POS_W-1:0]     position,
	input  logic [iss_pkg::WORD_W-1:0]    value_in,
	output logic                          done,
	output logic [iss_pkg::WORD_W-1:0]    value_out,
	output logic [iss_pkg::STATUS_W-1:0]  status,
	output logic [iss_pkg::CNT_OUT_W-1:0] entry_count
);
	import iss_pkg::*;

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	cell_cmd_t         cmd;
	logic [IW-1:0]     cmd_idx;
	logic [WORD_W-1:0] words [MAX_ENTRIES];
	logic [WORD_W-1:0] taps  [MAX_ENTRIES];

	iss_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.IW         (IW),
		.CW         (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.position   (position),
		.value_in   (value_in),
		.tap_head   (taps[0]),
		.busy       (busy),
		.done       (done),
		.value_out  (value_out),
		.status     (status),
		.entry_count(entry_count),
		.cmd        (cmd),
		.cmd_idx    (cmd_idx)
	);

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		logic [WORD_W-1:0] right_t;

		if (g == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_body_l
			assign left_w = words[g-1];
		end

		if (g == MAX_ENTRIES - 1) begin : g_tail
			assign right_w = words[g];
			assign right_t = '0;
		end else begin : g_body_r
			assign right_w = words[g+1];
			assign right_t = taps[g+1];
		end

		iss_cell #(
			.IW (IW),
			.IDX(g)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.idx       (cmd_idx),
			.left_word (left_w),
			.right_word(right_w),
			.right_tap (right_t),
			.word      (words[g]),
			.tap       (taps[g])
		);
	end

endmodule
